// ===== rtl/core/trilinear_cell_weights_core_assert.svh =====
// Assertion macros for the trilinear cell weights core.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef TRILINEAR_CELL_WEIGHTS_CORE_ASSERT_SVH
`define TRILINEAR_CELL_WEIGHTS_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TCW_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TCW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/tcw_pkg.sv =====
// Shared types and constants of the trilinear cell weights core.
// No dependencies; imported by trilinear_cell_weights_core.
package tcw_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int DATA_W        = 32;

  typedef logic signed [DATA_W-1:0] fx_t;
  typedef logic [DATA_W-1:0]        word_t;

  localparam fx_t FX_MAX = 32'sh7FFF_FFFF;
  localparam fx_t FX_MIN = 32'sh8000_0000;

  // Factor slots per axis: the local coordinate itself or one minus it.
  localparam int SEL_DIRECT = 0;
  localparam int SEL_COMPL  = 1;

  // First-product pairs 0..3 in corner order: (1-a)(1-b), a(1-b), ab, (1-a)b.
  localparam logic [3:0] PAIR_USE_A = 4'b0110;
  localparam logic [3:0] PAIR_USE_B = 4'b1100;

  // Local coordinates and inside flag carried alongside the weight datapath.
  typedef struct packed {
    fx_t [2:0] coord;
    logic      in_cell;
  } side_t;

endpackage

// ===== rtl/core/trilinear_cell_weights_core.sv =====
// Top level of the trilinear cell weights core: nine-stage datapath.
// Depends on tcw_pkg and trilinear_cell_weights_core_assert.svh.
//
// Usage: a request on the in_ channel carries a query point and the base
// corner of an axis-aligned cube cell. The out_ channel returns the three
// local coordinates, the eight trilinear corner weights and the inside flag,
// all signed fixed point with FRAC_BITS fraction bits and saturated to 32 bits.
// cfg_wr_en with cfg_wr_data loads the reciprocal cube size; a value of zero
// maps every point to local coordinate zero. The datapath has nine register
// stages, and its throughput is one request per clock while the receiver keeps
// out_ready high, set by the pipeline depth of one multiply per stage (3 local,
// 4 first, 16 partial).
// Reset empties every stage and loads the reciprocal with 1.0.
// When the receiver stalls, each full stage holds while empty stages upstream
// of it keep filling, so in_ready drops only once all nine stages are occupied.
`include "trilinear_cell_weights_core_assert.svh"

module trilinear_cell_weights_core #(
  parameter int FRAC_BITS = tcw_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_wr_en,
  input  tcw_pkg::word_t cfg_wr_data,
  input  logic          in_valid,
  output logic          in_ready,
  input  tcw_pkg::fx_t  in_point_x,
  input  tcw_pkg::fx_t  in_point_y,
  input  tcw_pkg::fx_t  in_point_z,
  input  tcw_pkg::fx_t  in_corner_x,
  input  tcw_pkg::fx_t  in_corner_y,
  input  tcw_pkg::fx_t  in_corner_z,
  output logic          out_valid,
  input  logic          out_ready,
  output tcw_pkg::fx_t  out_local_alpha,
  output tcw_pkg::fx_t  out_local_beta,
  output tcw_pkg::fx_t  out_local_gamma,
  output tcw_pkg::fx_t  out_weight_0,
  output tcw_pkg::fx_t  out_weight_1,
  output tcw_pkg::fx_t  out_weight_2,
  output tcw_pkg::fx_t  out_weight_3,
  output tcw_pkg::fx_t  out_weight_4,
  output tcw_pkg::fx_t  out_weight_5,
  output tcw_pkg::fx_t  out_weight_6,
  output tcw_pkg::fx_t  out_weight_7,
  output logic          out_inside_cell
);
  import tcw_pkg::*;

  localparam int NS = 9;
  localparam int W1 = 32 + FRAC_BITS;       // clamped first-product magnitude
  localparam int HW = 32 + FRAC_BITS;       // upper partial product
  localparam int PW = 64 + FRAC_BITS;       // full second product
  localparam word_t             ONE_U   = word_t'(1) << FRAC_BITS;
  localparam logic signed [32:0] ONE33  = 33'(ONE_U);
  localparam logic [64:0]        HALF65 = 65'(1) << (FRAC_BITS - 1);
  localparam logic [64:0]        CLAMP65 = 65'(1) << (31 + FRAC_BITS);
  localparam logic [PW-1:0]      HALFP  = PW'(1) << (FRAC_BITS - 1);

  logic [NS-1:0] v_r;
  logic [NS-1:0] en;
  word_t         inv_r;

  fx_t pt [3];
  fx_t cr [3];

  logic signed [32:0] diff_r   [3];
  logic signed [32:0] diff_nxt [3];
  logic [64:0]        lp_r     [3];
  logic [64:0]        lp_nxt   [3];
  logic               lneg_r   [3];
  fx_t                loc_r    [3];
  fx_t                loc_nxt  [3];
  logic [31:0]        fmag_r   [6];
  logic [31:0]        fmag_nxt [6];
  logic               fneg_r   [6];
  logic               fneg_nxt [6];
  logic               inside_nxt;
  logic [63:0]        p1_r     [4];
  logic [63:0]        p1_nxt   [4];
  logic               pneg_r   [4];
  logic               pneg_nxt [4];
  logic [31:0]        gm4_r    [2];
  logic               gn4_r    [2];
  logic [W1-1:0]      m1_r     [4];
  logic [W1-1:0]      m1_nxt   [4];
  logic               pneg5_r  [4];
  logic [31:0]        gm5_r    [2];
  logic               gn5_r    [2];
  logic [63:0]        lo_r     [8];
  logic [63:0]        lo_nxt   [8];
  logic [HW-1:0]      hi_r     [8];
  logic [HW-1:0]      hi_nxt   [8];
  logic               wneg_r   [8];
  logic               wneg_nxt [8];
  logic [PW-1:0]      pp_r     [8];
  logic [PW-1:0]      pp_nxt   [8];
  logic               wneg7_r  [8];
  fx_t                w_r      [8];
  fx_t                w_nxt    [8];
  side_t              side_r   [3:8];

  assign pt[0] = in_point_x;
  assign pt[1] = in_point_y;
  assign pt[2] = in_point_z;
  assign cr[0] = in_corner_x;
  assign cr[1] = in_corner_y;
  assign cr[2] = in_corner_z;

  // A stage may load when it is empty or when the stage after it loads.
  always_comb begin
    en[NS-1] = !v_r[NS-1] || out_ready;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r   <= '0;
      inv_r <= ONE_U;
    end else begin
      if (cfg_wr_en) begin
        inv_r <= cfg_wr_data;
      end
      if (en[0]) begin
        v_r[0] <= in_valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (en[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  // Stage 0: exact 33-bit differences.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff_nxt[i] = 33'(pt[i]) - 33'(cr[i]);
    end
  end

  // Stage 1: magnitude times reciprocal; the product stays below 2^64.
  always_comb begin
    logic [32:0] dmag;
    for (int i = 0; i < 3; i++) begin
      dmag      = diff_r[i][32] ? (~diff_r[i] + 33'd1) : diff_r[i];
      lp_nxt[i] = 65'(dmag) * 65'(inv_r);
    end
  end

  // Stage 2: round half away from zero, restore sign, saturate.
  always_comb begin
    logic [64:0] lsum;
    logic [31:0] lm;
    logic        big;
    for (int i = 0; i < 3; i++) begin
      lsum = lp_r[i] + HALF65;
      big  = |lsum[64:31+FRAC_BITS];
      lm   = {1'b0, lsum[FRAC_BITS+30:FRAC_BITS]};
      if (big) begin
        loc_nxt[i] = lneg_r[i] ? FX_MIN : FX_MAX;
      end else begin
        loc_nxt[i] = lneg_r[i] ? fx_t'(~lm + 32'd1) : fx_t'(lm);
      end
    end
  end

  // Stage 3: factor magnitudes and signs for each axis and its complement.
  always_comb begin
    logic signed [32:0] cd;
    logic signed [32:0] cc;
    logic               in_all;
    in_all = 1'b1;
    for (int i = 0; i < 3; i++) begin
      cd = 33'(loc_r[i]);
      cc = ONE33 - cd;
      fmag_nxt[2*i+SEL_DIRECT] = cd[32] ? 32'(~cd + 33'd1) : cd[31:0];
      fneg_nxt[2*i+SEL_DIRECT] = cd[32];
      fmag_nxt[2*i+SEL_COMPL]  = cc[32] ? 32'(~cc + 33'd1) : cc[31:0];
      fneg_nxt[2*i+SEL_COMPL]  = cc[32];
      in_all = in_all && !cd[32] && (cd <= ONE33);
    end
    inside_nxt = in_all;
  end

  // Stage 4: the four distinct products of the x and y factors.
  always_comb begin
    int sa;
    int sb;
    for (int j = 0; j < 4; j++) begin
      sa          = PAIR_USE_A[j] ? SEL_DIRECT : SEL_COMPL;
      sb          = PAIR_USE_B[j] ? 2 + SEL_DIRECT : 2 + SEL_COMPL;
      p1_nxt[j]   = 64'(fmag_r[sa]) * 64'(fmag_r[sb]);
      pneg_nxt[j] = fneg_r[sa] ^ fneg_r[sb];
    end
  end

  // Stage 5: round the first product. Any magnitude at or above 2^(31+F)
  // saturates the weight unless the z factor is zero, so it is clamped to
  // keep the next multiply narrow.
  always_comb begin
    logic [64:0] s1;
    logic [64:0] m1f;
    for (int j = 0; j < 4; j++) begin
      s1  = 65'(p1_r[j]) + HALF65;
      m1f = s1 >> FRAC_BITS;
      m1_nxt[j] = (m1f > CLAMP65) ? CLAMP65[W1-1:0] : m1f[W1-1:0];
    end
  end

  // Stage 6: second multiply in two partial products per weight.
  always_comb begin
    int j;
    int s;
    for (int k = 0; k < 8; k++) begin
      j           = k % 4;
      s           = (k >= 4) ? SEL_DIRECT : SEL_COMPL;
      lo_nxt[k]   = 64'(m1_r[j][31:0]) * 64'(gm5_r[s]);
      hi_nxt[k]   = HW'(m1_r[j][W1-1:32]) * HW'(gm5_r[s]);
      wneg_nxt[k] = pneg5_r[j] ^ gn5_r[s];
    end
  end

  // Stage 7: combine partials and add the rounding half.
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      pp_nxt[k] = (PW'(hi_r[k]) << 32) + PW'(lo_r[k]) + HALFP;
    end
  end

  // Stage 8: shift, restore sign, saturate.
  always_comb begin
    logic        big;
    logic [31:0] wm;
    for (int k = 0; k < 8; k++) begin
      big = |pp_r[k][PW-1:31+FRAC_BITS];
      wm  = {1'b0, pp_r[k][FRAC_BITS+30:FRAC_BITS]};
      if (big) begin
        w_nxt[k] = wneg7_r[k] ? FX_MIN : FX_MAX;
      end else begin
        w_nxt[k] = wneg7_r[k] ? fx_t'(~wm + 32'd1) : fx_t'(wm);
      end
    end
  end

  // Datapath registers: no reset, loaded with their stage enable.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      diff_r <= diff_nxt;
    end
    if (en[1]) begin
      lp_r <= lp_nxt;
      for (int i = 0; i < 3; i++) begin
        lneg_r[i] <= diff_r[i][32];
      end
    end
    if (en[2]) begin
      loc_r <= loc_nxt;
    end
    if (en[3]) begin
      fmag_r <= fmag_nxt;
      fneg_r <= fneg_nxt;
      side_r[3] <= '{coord: {loc_r[2], loc_r[1], loc_r[0]}, in_cell: inside_nxt};
    end
    if (en[4]) begin
      p1_r   <= p1_nxt;
      pneg_r <= pneg_nxt;
      gm4_r  <= '{fmag_r[4+SEL_DIRECT], fmag_r[4+SEL_COMPL]};
      gn4_r  <= '{fneg_r[4+SEL_DIRECT], fneg_r[4+SEL_COMPL]};
    end
    if (en[5]) begin
      m1_r    <= m1_nxt;
      pneg5_r <= pneg_r;
      gm5_r   <= gm4_r;
      gn5_r   <= gn4_r;
    end
    if (en[6]) begin
      lo_r   <= lo_nxt;
      hi_r   <= hi_nxt;
      wneg_r <= wneg_nxt;
    end
    if (en[7]) begin
      pp_r    <= pp_nxt;
      wneg7_r <= wneg_r;
    end
    if (en[8]) begin
      w_r <= w_nxt;
    end
    for (int i = 4; i < NS; i++) begin
      if (en[i]) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  assign out_valid       = v_r[NS-1];
  assign out_local_alpha = side_r[8].coord[0];
  assign out_local_beta  = side_r[8].coord[1];
  assign out_local_gamma = side_r[8].coord[2];
  assign out_inside_cell = side_r[8].in_cell;
  assign out_weight_0    = w_r[0];
  assign out_weight_1    = w_r[1];
  assign out_weight_2    = w_r[2];
  assign out_weight_3    = w_r[3];
  assign out_weight_4    = w_r[4];
  assign out_weight_5    = w_r[5];
  assign out_weight_6    = w_r[6];
  assign out_weight_7    = w_r[7];

  `TCW_ASSERT_NEXT(a_accept_enters, in_valid && in_ready, v_r[0],
    "accepted request lost at entry")
  `TCW_ASSERT_IMPLIES(a_ready_when_drained, !out_valid, in_ready,
    "ready low with empty output")
  `TCW_ASSERT_IMPLIES(a_inside_range, out_valid && out_inside_cell,
    !out_local_alpha[31] && (out_local_alpha <= ONE33) &&
    !out_local_beta[31] && (out_local_beta <= ONE33) &&
    !out_local_gamma[31] && (out_local_gamma <= ONE33),
    "inside flag disagrees with coordinates")
  `TCW_ASSERT_IMPLIES(a_origin_weights,
    out_valid && (out_local_alpha == 0) && (out_local_beta == 0) && (out_local_gamma == 0),
    (out_weight_0 == ONE33) && (out_weight_1 == 0) && (out_weight_6 == 0) && out_inside_cell,
    "weights wrong at cell origin")

endmodule

// ===== tb/trilinear_cell_weights_core_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for trilinear_cell_weights_core: sends cell queries, predicts the
// local coordinates, corner weights and inside flag, and checks every response in order.
// Depends on tcw_pkg and the core RTL only.
module trilinear_cell_weights_core_test;
  import tcw_pkg::*;

  localparam int     FRAC         = FRAC_BITS_DEF;
  localparam longint ONE_FX       = 64'sd1 << FRAC;
  localparam fx_t    UNIT         = 32'sh0001_0000;
  localparam word_t  INV_RESET    = 32'h0001_0000;
  localparam int     RESULT_WORDS = 11;
  localparam int     PIPE_DEPTH   = 9;
  localparam int     IDLE_MAX     = 17;
  localparam int     REPORT_MAX   = 10;
  localparam int     CYCLE_LIMIT  = 500000;
  localparam int     PHASE_ITEMS  = 250;

  // val[0..2] are the local coordinates, val[3..10] the weights in corner order.
  typedef struct packed {
    fx_t [RESULT_WORDS-1:0] val;
    logic                   in_cell;
  } cell_result_t;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  cfg_wr_en = 1'b0;
  word_t cfg_wr_data = '0;
  logic  in_valid = 1'b0;
  logic  in_ready;
  fx_t   in_point_x = '0;
  fx_t   in_point_y = '0;
  fx_t   in_point_z = '0;
  fx_t   in_corner_x = '0;
  fx_t   in_corner_y = '0;
  fx_t   in_corner_z = '0;
  logic  out_valid;
  logic  out_ready = 1'b0;
  fx_t   out_local_alpha, out_local_beta, out_local_gamma;
  fx_t   out_weight_0, out_weight_1, out_weight_2, out_weight_3;
  fx_t   out_weight_4, out_weight_5, out_weight_6, out_weight_7;
  logic  out_inside_cell;

  word_t        inv_size_model;
  cell_result_t cell_weight_q[$];
  bit           tx_idle_on;
  bit           rx_idle_on;
  int           rx_stall_left;
  int           mismatch_count;
  int           cycle_count;
  string        field_name [RESULT_WORDS] = '{"local_alpha", "local_beta", "local_gamma",
    "weight_0", "weight_1", "weight_2", "weight_3",
    "weight_4", "weight_5", "weight_6", "weight_7"};

  trilinear_cell_weights_core u_top (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_point_x(in_point_x),
    .in_point_y(in_point_y),
    .in_point_z(in_point_z),
    .in_corner_x(in_corner_x),
    .in_corner_y(in_corner_y),
    .in_corner_z(in_corner_z),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_local_alpha(out_local_alpha),
    .out_local_beta(out_local_beta),
    .out_local_gamma(out_local_gamma),
    .out_weight_0(out_weight_0),
    .out_weight_1(out_weight_1),
    .out_weight_2(out_weight_2),
    .out_weight_3(out_weight_3),
    .out_weight_4(out_weight_4),
    .out_weight_5(out_weight_5),
    .out_weight_6(out_weight_6),
    .out_weight_7(out_weight_7),
    .out_inside_cell(out_inside_cell)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Fixed-point product, rounded half away from zero on the magnitude.
  // The magnitude is clamped to 2^62, which only happens when the final value saturates.
  function automatic longint fx_product(longint x, longint y);
    logic [63:0]  mx;
    logic [63:0]  my;
    logic [63:0]  mag;
    logic [127:0] prod;
    mx = (x < 0) ? -x : x;
    my = (y < 0) ? -y : y;
    prod = {64'd0, mx} * {64'd0, my};
    prod = prod + (128'd1 << (FRAC - 1));
    if (prod > 128'hFFFF_FFFF_FFFF_FFFF) begin
      mag = 64'd1 << 62;
    end else begin
      mag = 64'(prod >> FRAC);
      if (mag > (64'd1 << 62)) mag = 64'd1 << 62;
    end
    return ((x < 0) != (y < 0)) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint clamp_s32(longint v);
    if (v > longint'(FX_MAX)) return longint'(FX_MAX);
    if (v < longint'(FX_MIN)) return longint'(FX_MIN);
    return v;
  endfunction

  function automatic cell_result_t predict_cell(fx_t px, fx_t py, fx_t pz,
                                                fx_t cx, fx_t cy, fx_t cz);
    cell_result_t r;
    fx_t          pt [3];
    fx_t          cn [3];
    longint       loc [3];
    longint       cmp [3];
    longint       fa, fb, fg;
    pt = '{px, py, pz};
    cn = '{cx, cy, cz};
    r.in_cell = 1'b1;
    for (int i = 0; i < 3; i++) begin
      loc[i] = clamp_s32(fx_product(longint'(pt[i]) - longint'(cn[i]),
                                    longint'(inv_size_model)));
      cmp[i] = ONE_FX - loc[i];
      r.val[i] = fx_t'(loc[i]);
      if (loc[i] < 0 || loc[i] > ONE_FX) r.in_cell = 1'b0;
    end
    for (int k = 0; k < 8; k++) begin
      fa = PAIR_USE_A[k % 4] ? loc[0] : cmp[0];
      fb = PAIR_USE_B[k % 4] ? loc[1] : cmp[1];
      fg = (k >= 4) ? loc[2] : cmp[2];
      r.val[3 + k] = fx_t'(clamp_s32(fx_product(fx_product(fa, fb), fg)));
    end
    return r;
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] want, got);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX)
      $display("MISMATCH %s: expected %h, actual %h", what, want, got);
  endtask

  // Response side: checks each accepted response and draws the stall before the next one.
  always @(posedge clk) begin : response_check
    cell_result_t got;
    cell_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        got.val = {out_weight_7, out_weight_6, out_weight_5, out_weight_4,
                   out_weight_3, out_weight_2, out_weight_1, out_weight_0,
                   out_local_gamma, out_local_beta, out_local_alpha};
        got.in_cell = out_inside_cell;
        if (cell_weight_q.size() == 0) begin
          note_mismatch("response with no request pending", '0, got.val[0]);
        end else begin
          want = cell_weight_q.pop_front();
          for (int i = 0; i < RESULT_WORDS; i++) begin
            if (got.val[i] !== want.val[i]) note_mismatch(field_name[i], want.val[i], got.val[i]);
          end
          if (got.in_cell !== want.in_cell)
            note_mismatch("inside_cell", {31'd0, want.in_cell}, {31'd0, got.in_cell});
        end
        rx_stall_left = rx_idle_on ? $urandom_range(0, IDLE_MAX) : 0;
      end
      if (rx_stall_left > 0) begin
        rx_stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Valid is left high after acceptance so that back-to-back requests never toggle it.
  task automatic send_query(input fx_t px, py, pz, cx, cy, cz);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, IDLE_MAX) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_point_x <= px;
    in_point_y <= py;
    in_point_z <= pz;
    in_corner_x <= cx;
    in_corner_y <= cy;
    in_corner_z <= cz;
    do @(posedge clk); while (!in_ready);
    cell_weight_q.push_back(predict_cell(px, py, pz, cx, cy, cz));
  endtask

  task automatic drain_responses();
    in_valid <= 1'b0;
    while (cell_weight_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_inv_size(input word_t value);
    drain_responses();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    inv_size_model = value;
  endtask

  // Point placed so that each local coordinate lands mostly in [-0.25, 1.25],
  // with the cell faces hit exactly now and then.
  task automatic send_cell_query();
    fx_t    cn [3];
    fx_t    pt [3];
    longint target;
    longint diff;
    for (int i = 0; i < 3; i++) begin
      cn[i] = fx_t'($urandom);
      case ($urandom_range(0, 9))
        0:       target = 0;
        1:       target = ONE_FX;
        default: target = longint'($urandom_range(0, 98304)) - 16384;
      endcase
      if (inv_size_model == '0) diff = longint'($urandom_range(0, 131072)) - 65536;
      else diff = (target <<< FRAC) / longint'(inv_size_model);
      pt[i] = fx_t'(clamp_s32(longint'(cn[i]) + diff));
    end
    send_query(pt[0], pt[1], pt[2], cn[0], cn[1], cn[2]);
  endtask

  task automatic test_unit_cell();
    fx_t base;
    base = 32'sh0123_4567;
    send_query(0, 0, 0, 0, 0, 0);
    send_query(base + UNIT, base + UNIT, base + UNIT, base, base, base);
    send_query(base + 32'sh8000, base + 32'sh4000, base + 32'shC000, base, base, base);
    // Just outside the lower face in x, then just outside the upper face in z.
    send_query(base - 1, base, base + UNIT, base, base, base);
    send_query(base, base + UNIT, base + UNIT + 1, base, base, base);
    send_query(base + UNIT, base - UNIT, base + 32'sh8000, base, base, base);
    send_query(FX_MAX, FX_MAX, FX_MAX, FX_MIN, FX_MIN, FX_MIN);
    send_query(FX_MIN, FX_MIN, FX_MIN, FX_MAX, FX_MAX, FX_MAX);
    send_query(-1, -1, -1, 0, 0, 0);
    send_query(32'sh5555_5555, 32'sh5555_5555, 32'sh5555_5555,
               32'shAAAA_AAAA, 32'shAAAA_AAAA, 32'shAAAA_AAAA);
    send_query(32'shAAAA_AAAA, 32'shAAAA_AAAA, 32'shAAAA_AAAA,
               32'sh5555_5555, 32'sh5555_5555, 32'sh5555_5555);
    drain_responses();
  endtask

  // A zero reciprocal maps every point onto the base corner.
  task automatic test_undefined_size();
    write_inv_size('0);
    send_query(0, 0, 0, 0, 0, 0);
    send_query(FX_MAX, FX_MIN, FX_MAX, FX_MIN, FX_MAX, FX_MIN);
    send_query($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    drain_responses();
  endtask

  task automatic test_scale_extremes();
    write_inv_size(32'hFFFF_FFFF);
    send_query(1, -1, UNIT, 0, 0, 0);
    send_query(FX_MAX, FX_MIN, 0, FX_MIN, FX_MAX, 0);
    write_inv_size(32'h0000_0001);
    // Half-LSB products round away from zero in both signs.
    send_query(32'sh8000, -32'sh8000, FX_MAX, 0, 0, FX_MIN);
    send_query(32'sh7FFF, -32'sh7FFF, FX_MIN, 0, 0, FX_MAX);
    write_inv_size(32'h0000_8000);
    send_query(1, -1, 3, 0, 0, 0);
    send_query(2 * UNIT, UNIT, -3, 0, 0, 0);
    drain_responses();
  endtask

  task automatic test_random_sweep();
    word_t scale [8];
    scale = '{INV_RESET, $urandom, 32'h0000_8000, 32'h0004_0000,
              $urandom_range(1, 32'h0010_0000), 32'hFFFF_FFFF, 32'h0000_0000, $urandom};
    for (int ph = 0; ph < 8; ph++) begin
      write_inv_size(scale[ph]);
      tx_idle_on = ph[0];
      rx_idle_on = ph[1];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2) tx_idle_on = !tx_idle_on;
        if ($urandom_range(0, 9) < 7) send_cell_query();
        else send_query($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end
    end
    drain_responses();
  endtask

  initial begin
    inv_size_model = INV_RESET;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_unit_cell();
    test_undefined_size();
    test_scale_extremes();
    test_random_sweep();
    drain_responses();
    repeat (PIPE_DEPTH * 4) @(posedge clk);
    if (mismatch_count == 0 && cell_weight_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
